/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the histogram unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication under reset");

`endif

/* hw/rtl/cgh_pkg.sv */
// Types, constants and helper functions of the chaos game histogram unit.
`timescale 1ns / 1ps

package cgh_pkg;

   localparam int GRID_SIZE   = 128;
   localparam int CELL_BITS   = $clog2(GRID_SIZE);
   localparam int GRID_BITS   = CELL_BITS + 1;
   localparam int FRAC_BITS   = 24;
   localparam int POS_WIDTH   = CELL_BITS + FRAC_BITS;
   localparam int COUNT_WIDTH = 32;
   localparam int ADDR_BITS   = 2 * CELL_BITS;
   localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;
   localparam int OCC_WIDTH   = ADDR_BITS + 1;

   localparam int CMD_WIDTH       = 2;
   localparam int CODE_WIDTH      = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [GRID_BITS-1:0] GRID_RESET = GRID_BITS'(GRID_SIZE);
   localparam logic [GRID_BITS-1:0] GRID_MIN   = GRID_BITS'(2);
   localparam logic [GRID_BITS-1:0] GRID_MAX   = GRID_BITS'(GRID_SIZE);
   localparam logic [POS_WIDTH-1:0] RESET_CENTRE =
      POS_WIDTH'(GRID_SIZE / 2) << FRAC_BITS;
   localparam logic [POS_WIDTH:0] ROUND_HALF = (POS_WIDTH + 1)'(1) << (FRAC_BITS - 1);

   localparam logic [CODE_WIDTH-1:0] NUCLEOTIDE_CODES = CODE_WIDTH'(4);
   localparam logic [CODE_WIDTH-1:0] PROTEIN_CODES    = CODE_WIDTH'(20);

   localparam logic [CMD_WIDTH-1:0] CMD_SYMBOL = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_START  = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ALPHABET = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GRID     = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_COUNT = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } cgh_op_type;

   typedef struct packed {
      cgh_op_type           kind;
      logic [CELL_BITS-1:0] row;
      logic [CELL_BITS-1:0] col;
   } cgh_entry_type;

   typedef struct packed {
      logic                 alphabet;
      logic                 rnd;
      logic [GRID_BITS-1:0] grid;
   } cgh_cfg_type;

   typedef struct packed {
      logic q_full;
      logic clearing;
   } cgh_flow_type;

   // Protein residues fall into four charge and polarity classes.
   function automatic logic [1:0] protein_class(input logic [CODE_WIDTH-1:0] code);
      logic [1:0] cls;
      unique case (code) inside
         5'd3, 5'd6:                                  cls = 2'd1;
         5'd1, 5'd8, 5'd11:                           cls = 2'd3;
         5'd2, 5'd4, 5'd5, 5'd7, 5'd15, 5'd16, 5'd18: cls = 2'd2;
         default:                                     cls = 2'd0;
      endcase
      return cls;
   endfunction

endpackage

/* hw/rtl/cgh_interfaces.sv */
// Request and response channel interfaces of the histogram unit.
`timescale 1ns / 1ps

interface cgh_req_if import cgh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CMD_WIDTH-1:0]  command;
   logic [CODE_WIDTH-1:0] symbol_code;
   logic [CELL_BITS-1:0]  read_row;
   logic [CELL_BITS-1:0]  read_col;

   modport source (output valid, command, symbol_code, read_row, read_col, input ready);
   modport sink   (input valid, command, symbol_code, read_row, read_col, output ready);
endinterface

interface cgh_rsp_if import cgh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   point_valid;
   logic [CELL_BITS-1:0]   cell_row;
   logic [CELL_BITS-1:0]   cell_col;
   logic [COUNT_WIDTH-1:0] cell_count;
   logic [OCC_WIDTH-1:0]   nonzero_cells;

   modport source (output valid, point_valid, cell_row, cell_col, cell_count, nonzero_cells,
                   input ready);
   modport sink   (input valid, point_valid, cell_row, cell_col, cell_count, nonzero_cells,
                   output ready);
endinterface

/* hw/rtl/cgh_front.sv */
// Front end: accepts requests, classifies symbols and moves the point.
`timescale 1ns / 1ps

module cgh_front import cgh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cgh_req_if.sink       req_bus,
   input  cgh_cfg_type   cfg,
   input  cgh_flow_type  flow,
   output logic          push,
   output cgh_entry_type push_entry
);

   logic [POS_WIDTH-1:0] pos_x_ff, pos_x_in;
   logic [POS_WIDTH-1:0] pos_y_ff, pos_y_in;

   logic                 accept;
   logic                 sym_ok;
   logic [1:0]           cls;
   logic [GRID_BITS-1:0] g_eff;
   logic [CELL_BITS-1:0] g_last;
   logic [POS_WIDTH-1:0] far_edge;
   logic [POS_WIDTH-1:0] corner_x, corner_y, centre;
   logic [POS_WIDTH:0]   sum_x, sum_y;
   logic [POS_WIDTH-1:0] step_x, step_y;

   // Maps a position to its cell, by floor or by round-half-up, clamped to the grid.
   function automatic logic [CELL_BITS-1:0] to_cell(input logic [POS_WIDTH-1:0] p,
                                                    input logic rnd,
                                                    input logic [CELL_BITS-1:0] last);
      logic [POS_WIDTH:0]   biased;
      logic [GRID_BITS-1:0] c;
      biased = {1'b0, p} + (rnd ? ROUND_HALF : '0);
      c      = biased[POS_WIDTH:FRAC_BITS];
      return (c > {1'b0, last}) ? last : c[CELL_BITS-1:0];
   endfunction

   assign req_bus.ready = !flow.q_full && !flow.clearing;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept;

   always_comb begin
      if (cfg.grid < GRID_MIN) begin
         g_eff = GRID_MIN;
      end else if (cfg.grid > GRID_MAX) begin
         g_eff = GRID_MAX;
      end else begin
         g_eff = cfg.grid;
      end
      g_last   = CELL_BITS'(g_eff - GRID_BITS'(1));
      far_edge = {g_last, {FRAC_BITS{1'b0}}};
      centre   = {g_eff[GRID_BITS-1:1], {FRAC_BITS{1'b0}}};

      if (cfg.alphabet) begin
         sym_ok = req_bus.symbol_code < PROTEIN_CODES;
         cls    = protein_class(req_bus.symbol_code);
      end else begin
         sym_ok = req_bus.symbol_code < NUCLEOTIDE_CODES;
         cls    = req_bus.symbol_code[1:0];
      end

      // Classes two and three sit on the far x edge; one and two on the far y edge.
      corner_x = cls[1] ? far_edge : '0;
      corner_y = (cls[1] ^ cls[0]) ? far_edge : '0;
      sum_x    = {1'b0, corner_x} + {1'b0, pos_x_ff};
      sum_y    = {1'b0, corner_y} + {1'b0, pos_y_ff};
      step_x   = sum_x[POS_WIDTH:1];
      step_y   = sum_y[POS_WIDTH:1];

      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      push_entry = '{kind: OP_NONE, row: '0, col: '0};

      if (accept) begin
         unique case (req_bus.command)
            CMD_SYMBOL: begin
               if (sym_ok) begin
                  pos_x_in   = step_x;
                  pos_y_in   = step_y;
                  push_entry = '{kind: OP_COUNT,
                                 row:  to_cell(step_x, cfg.rnd, g_last),
                                 col:  to_cell(step_y, cfg.rnd, g_last)};
               end
            end
            CMD_READ: begin
               push_entry = '{kind: OP_READ, row: req_bus.read_row, col: req_bus.read_col};
            end
            CMD_START: begin
               pos_x_in   = centre;
               pos_y_in   = centre;
               push_entry = '{kind: OP_CLEAR, row: '0, col: '0};
            end
            default: begin
               push_entry = '{kind: OP_NONE, row: '0, col: '0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= RESET_CENTRE;
         pos_y_ff <= RESET_CENTRE;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

endmodule

/* hw/rtl/cgh_queue.sv */
// Short first-in first-out queue of operations between front and back end.
`timescale 1ns / 1ps

module cgh_queue import cgh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cgh_entry_type push_entry,
   input  logic          pop,
   output logic          head_valid,
   output cgh_entry_type head_entry,
   output logic          full
);

   cgh_entry_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign head_valid = count_ff != '0;
   assign full       = count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/cgh_back.sv */
// Back end: cell counter store with read-modify-write, clearing pass and response register.
`timescale 1ns / 1ps

module cgh_back import cgh_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cgh_entry_type head_entry,
   output logic          pop,
   output logic          clearing,
   cgh_rsp_if.source     rsp_bus
);

   logic [COUNT_WIDTH-1:0] cell_mem_ff [CELL_COUNT];
   logic [COUNT_WIDTH-1:0] rdata_ff;

   logic                   sweep_ff, sweep_in;
   logic [ADDR_BITS-1:0]   sweep_addr_ff, sweep_addr_in;

   logic                   b_valid_ff, b_valid_in;
   cgh_entry_type          b_entry_ff;

   logic                   wr_valid_ff, wr_valid_in;
   logic [ADDR_BITS-1:0]   wr_addr_ff;
   logic [COUNT_WIDTH-1:0] wr_data_ff;

   logic [OCC_WIDTH-1:0]   occupied_ff, occupied_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   out_point_ff;
   logic [CELL_BITS-1:0]   out_row_ff, out_col_ff;
   logic [COUNT_WIDTH-1:0] out_count_ff;
   logic [OCC_WIDTH-1:0]   out_nonzero_ff;

   logic                   advance, b_fire, count_we;
   logic [ADDR_BITS-1:0]   b_addr, rd_addr, mem_waddr;
   logic [COUNT_WIDTH-1:0] cur, bumped, mem_wdata;
   logic                   mem_we;
   logic                   res_point;
   logic [CELL_BITS-1:0]   res_row, res_col;
   logic [COUNT_WIDTH-1:0] res_count;

   assign clearing = sweep_ff;
   assign advance  = !out_valid_ff || rsp_bus.ready;
   assign b_fire   = b_valid_ff && advance;
   // Nothing enters the read stage behind a start command until its pass is over.
   assign pop      = head_valid && advance && !sweep_ff &&
                     !(b_valid_ff && b_entry_ff.kind == OP_CLEAR);
   assign rd_addr  = {head_entry.row, head_entry.col};
   assign b_addr   = {b_entry_ff.row, b_entry_ff.col};

   always_comb begin
      // The previous write lands at the edge where this read was sampled.
      cur    = (wr_valid_ff && wr_addr_ff == b_addr) ? wr_data_ff : rdata_ff;
      bumped = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

      occupied_in = occupied_ff;
      res_point   = 1'b0;
      res_row     = '0;
      res_col     = '0;
      res_count   = '0;
      case (b_entry_ff.kind)
         OP_COUNT: begin
            if (b_fire && cur == '0) begin
               occupied_in = occupied_ff + OCC_WIDTH'(1);
            end
            res_point = 1'b1;
            res_row   = b_entry_ff.row;
            res_col   = b_entry_ff.col;
            res_count = bumped;
         end
         OP_READ: begin
            res_row   = b_entry_ff.row;
            res_col   = b_entry_ff.col;
            res_count = cur;
         end
         OP_CLEAR: begin
            if (b_fire) begin
               occupied_in = '0;
            end
         end
         default: begin
            res_point = 1'b0;
         end
      endcase

      count_we  = b_fire && b_entry_ff.kind == OP_COUNT;
      mem_we    = sweep_ff || count_we;
      mem_waddr = sweep_ff ? sweep_addr_ff : b_addr;
      mem_wdata = sweep_ff ? '0 : bumped;

      sweep_in      = sweep_ff;
      sweep_addr_in = sweep_addr_ff;
      if (sweep_ff) begin
         sweep_addr_in = sweep_addr_ff + ADDR_BITS'(1);
         if (sweep_addr_ff == '1) begin
            sweep_in = 1'b0;
         end
      end else if (b_fire && b_entry_ff.kind == OP_CLEAR) begin
         sweep_in      = 1'b1;
         sweep_addr_in = '0;
      end

      wr_valid_in = sweep_ff ? 1'b0 : (count_we ? 1'b1 : wr_valid_ff);

      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end else begin
         b_valid_in = b_valid_ff;
      end

      out_valid_in = advance ? b_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         b_valid_ff    <= 1'b0;
         wr_valid_ff   <= 1'b0;
         occupied_ff   <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         sweep_ff      <= sweep_in;
         sweep_addr_ff <= sweep_addr_in;
         b_valid_ff    <= b_valid_in;
         wr_valid_ff   <= wr_valid_in;
         occupied_ff   <= occupied_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_entry_ff <= head_entry;
      end
      if (count_we) begin
         wr_addr_ff <= b_addr;
         wr_data_ff <= bumped;
      end
      if (b_fire) begin
         out_point_ff   <= res_point;
         out_row_ff     <= res_row;
         out_col_ff     <= res_col;
         out_count_ff   <= res_count;
         out_nonzero_ff <= occupied_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rdata_ff <= cell_mem_ff[rd_addr];
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.point_valid   = out_point_ff;
   assign rsp_bus.cell_row      = out_row_ff;
   assign rsp_bus.cell_col      = out_col_ff;
   assign rsp_bus.cell_count    = out_count_ff;
   assign rsp_bus.nonzero_cells = out_nonzero_ff;

endmodule

/* hw/rtl/chaos_game_histogram_unit.sv */
// Top level of the chaos game histogram unit: configuration registers and the datapath.
//
//   channel   direction  handshake            contents
//   req_bus   in         valid/ready          command, symbol_code, read_row, read_col
//   rsp_bus   out        valid/ready          point_valid, cell_row, cell_col,
//                                             cell_count, nonzero_cells
//   csr_*     in         csr_write, no ready  csr_index, csr_wdata
//
// One request is taken per cycle unless the queue is full or a clearing pass runs; its
// response goes through the queue, the registered store read and the response register.
// After reset, and after every start command, a clearing pass writes the 16384 counters
// one per cycle; req_bus.ready stays low while the pass runs.
// A stalled response holds its register; the four-entry queue keeps taking requests
// until it fills, after which req_bus.ready falls.
`timescale 1ns / 1ps

module chaos_game_histogram_unit import cgh_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   cgh_req_if.sink                    req_bus,
   cgh_rsp_if.source                  rsp_bus,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cgh_cfg_type   cfg_ff, cfg_in;
   cgh_flow_type  flow;
   logic          push, pop, head_valid, q_full, clearing;
   cgh_entry_type push_entry, head_entry;

   // Write registers only while the unit is idle; the block itself does not check this.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ALPHABET: cfg_in.alphabet = csr_wdata[0];
            CSR_ROUND:    cfg_in.rnd      = csr_wdata[0];
            CSR_GRID:     cfg_in.grid     = csr_wdata[GRID_BITS-1:0];
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{alphabet: 1'b0, rnd: 1'b0, grid: GRID_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign flow = '{q_full: q_full, clearing: clearing};

   // The front moves the point and works out the cell as the request is taken.
   cgh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .flow       (flow),
      .push       (push),
      .push_entry (push_entry)
   );

   cgh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (q_full)
   );

   // The back end owns the counter store and the count of occupied cells.
   cgh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* hw/rtl/cgh_checker.sv */
// Port-level checker of the histogram unit and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cgh_checker import cgh_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_point_valid,
   input logic [CELL_BITS-1:0]   rsp_cell_row,
   input logic [CELL_BITS-1:0]   rsp_cell_col,
   input logic [COUNT_WIDTH-1:0] rsp_cell_count,
   input logic [OCC_WIDTH-1:0]   rsp_nonzero_cells
);

   // Reset starts the clearing pass, so nothing is taken or shown just after it.
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !req_ready && !rsp_valid)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_cell_count) && $stable(rsp_nonzero_cells) &&
                $stable(rsp_cell_row) && $stable(rsp_cell_col))

   // A counted hit leaves its own cell nonzero.
   `ASSERT_IMPLY(a_hit_counted, clock, reset, rsp_valid && rsp_point_valid,
                 rsp_cell_count != '0 && rsp_nonzero_cells != '0)

   `ASSERT_IMPLY(a_occupancy_bound, clock, reset, rsp_valid,
                 rsp_nonzero_cells <= OCC_WIDTH'(CELL_COUNT))

endmodule

bind chaos_game_histogram_unit cgh_checker u_cgh_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_point_valid   (rsp_bus.point_valid),
   .rsp_cell_row      (rsp_bus.cell_row),
   .rsp_cell_col      (rsp_bus.cell_col),
   .rsp_cell_count    (rsp_bus.cell_count),
   .rsp_nonzero_cells (rsp_bus.nonzero_cells)
);

/* sim/tb_chaos_game_histogram_unit.sv */
// Self-checking testbench of the chaos game histogram unit, with its own behavioural predictor.
`timescale 1ns / 1ps

module tb_chaos_game_histogram_unit;
   import cgh_pkg::*;

   // Command 3 has no meaning in the block; it must leave every piece of state alone.
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   // The clearing pass after reset and after every start command keeps the request
   // channel quiet while it runs, and the watchdog limit leaves room for that.
   localparam int QUIET_LIMIT     = 4 * CELL_COUNT;
   localparam int LONG_HOLD       = 200;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int PRESSURE_PHASE  = 3;
   localparam int TAIL_CYCLES     = 8;

   // Corner that a symbol pulls the point towards, named by its x and y ends.
   typedef enum logic [2:0] {
      CORNER_X0_Y0 = 3'd0,
      CORNER_X0_YF = 3'd1,
      CORNER_XF_YF = 3'd2,
      CORNER_XF_Y0 = 3'd3,
      CORNER_NONE  = 3'd4
   } corner_type;

   typedef struct packed {
      logic                   point_valid;
      logic [CELL_BITS-1:0]   row;
      logic [CELL_BITS-1:0]   col;
      logic [COUNT_WIDTH-1:0] count;
      logic [OCC_WIDTH-1:0]   nonzero;
   } cell_report_type;

   // One line of the directed plan: either a register write or a request, the latter
   // optionally carrying a result that is typed in by hand.
   typedef struct {
      bit                         is_csr;
      logic [CSR_INDEX_WIDTH-1:0] reg_index;
      logic [CSR_DATA_WIDTH-1:0]  reg_value;
      logic [CMD_WIDTH-1:0]       command;
      logic [CODE_WIDTH-1:0]      code;
      logic [CELL_BITS-1:0]       row;
      logic [CELL_BITS-1:0]       col;
      bit                         fixed;
      cell_report_type            report;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   cgh_req_if req_bus ();
   cgh_rsp_if rsp_bus ();

   chaos_game_histogram_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: a private copy of the registers, the point and the counter store.
   logic                       cfg_protein;
   logic                       cfg_round;
   logic [CSR_DATA_WIDTH-1:0]  cfg_grid;
   logic [POS_WIDTH-1:0]       pos_x;
   logic [POS_WIDTH-1:0]       pos_y;
   logic [COUNT_WIDTH-1:0]     cell_store [CELL_COUNT];
   logic [OCC_WIDTH-1:0]       occupied;

   cell_report_type            pending_reports [$];
   directed_row_type           directed_plan [$];
   int                         mismatches = 0;
   bit                         req_idle_on = 1'b1;
   bit                         rsp_idle_on = 1'b1;
   bit                         hold_request = 1'b0;
   logic [CELL_BITS-1:0]       last_row = '0;
   logic [CELL_BITS-1:0]       last_col = '0;

   // The grid in use is the register value clamped to the range the store supports.
   function automatic logic [GRID_BITS-1:0] grid_in_use();
      if (cfg_grid < GRID_MIN) return GRID_MIN;
      if (cfg_grid > GRID_MAX) return GRID_MAX;
      return cfg_grid;
   endfunction

   function automatic void recentre_point();
      pos_x = POS_WIDTH'(grid_in_use() >> 1) << FRAC_BITS;
      pos_y = pos_x;
   endfunction

   function automatic void clear_store();
      foreach (cell_store[i]) cell_store[i] = '0;
      occupied = '0;
   endfunction

   // Nucleotides name their corner directly; residues fall into four charge and
   // polarity groups. Anything outside the alphabet is a gap and is skipped.
   function automatic corner_type corner_of(input logic [CODE_WIDTH-1:0] code);
      if (!cfg_protein) begin
         return (code < NUCLEOTIDE_CODES) ? corner_type'(code[2:0]) : CORNER_NONE;
      end
      if (code >= PROTEIN_CODES) return CORNER_NONE;
      case (code)
         5'd3, 5'd6:                                  return CORNER_X0_YF;
         5'd1, 5'd8, 5'd11:                           return CORNER_XF_Y0;
         5'd2, 5'd4, 5'd5, 5'd7, 5'd15, 5'd16, 5'd18: return CORNER_XF_YF;
         default:                                     return CORNER_X0_Y0;
      endcase
   endfunction

   // Floor or round-half-up to a cell, then pin to the far edge should the grid have
   // shrunk underneath the point.
   function automatic logic [CELL_BITS-1:0] cell_index(input logic [POS_WIDTH-1:0] p,
                                                       input logic [GRID_BITS-1:0] g);
      logic [POS_WIDTH:0]   biased;
      logic [GRID_BITS-1:0] c;
      biased = cfg_round ? {1'b0, p} + ROUND_HALF : {1'b0, p};
      c = GRID_BITS'(biased >> FRAC_BITS);
      if (c > g - GRID_BITS'(1)) c = g - GRID_BITS'(1);
      return CELL_BITS'(c);
   endfunction

   // Advances the predictor by one request and returns the response it should produce.
   function automatic cell_report_type histogram_step(input logic [CMD_WIDTH-1:0] cmd,
                                                      input logic [CODE_WIDTH-1:0] code,
                                                      input logic [CELL_BITS-1:0] rrow,
                                                      input logic [CELL_BITS-1:0] rcol);
      cell_report_type      r;
      corner_type           k;
      logic [GRID_BITS-1:0] g;
      logic [POS_WIDTH:0]   far;
      logic [POS_WIDTH:0]   cx;
      logic [POS_WIDTH:0]   cy;
      logic [ADDR_BITS-1:0] a;
      r = '0;
      g = grid_in_use();
      case (cmd)
         CMD_SYMBOL: begin
            k = corner_of(code);
            if (k != CORNER_NONE) begin
               far = (POS_WIDTH + 1)'(g - GRID_BITS'(1)) << FRAC_BITS;
               cx = (k == CORNER_XF_YF || k == CORNER_XF_Y0) ? far : '0;
               cy = (k == CORNER_X0_YF || k == CORNER_XF_YF) ? far : '0;
               pos_x = POS_WIDTH'((cx + {1'b0, pos_x}) >> 1);
               pos_y = POS_WIDTH'((cy + {1'b0, pos_y}) >> 1);
               r.row = cell_index(pos_x, g);
               r.col = cell_index(pos_y, g);
               a = {r.row, r.col};
               if (cell_store[a] == '0) occupied = occupied + 1'b1;
               if (cell_store[a] != COUNT_MAX) cell_store[a] = cell_store[a] + 1'b1;
               r.count = cell_store[a];
               r.point_valid = 1'b1;
            end
         end
         CMD_READ: begin
            r.row = rrow;
            r.col = rcol;
            r.count = cell_store[{rrow, rcol}];
         end
         CMD_START: begin
            clear_store();
            recentre_point();
         end
         default: begin
         end
      endcase
      r.nonzero = occupied;
      return r;
   endfunction

   function automatic directed_row_type csr_row(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                                input logic [CSR_DATA_WIDTH-1:0] value);
      directed_row_type d;
      d = '{default: '0};
      d.is_csr = 1'b1;
      d.reg_index = idx;
      d.reg_value = value;
      return d;
   endfunction

   function automatic directed_row_type req_row(input logic [CMD_WIDTH-1:0] cmd,
                                                input logic [CODE_WIDTH-1:0] code,
                                                input logic [CELL_BITS-1:0] row,
                                                input logic [CELL_BITS-1:0] col);
      directed_row_type d;
      d = '{default: '0};
      d.command = cmd;
      d.code = code;
      d.row = row;
      d.col = col;
      return d;
   endfunction

   function automatic directed_row_type checked_row(input logic [CMD_WIDTH-1:0] cmd,
                                                    input logic [CODE_WIDTH-1:0] code,
                                                    input logic [CELL_BITS-1:0] row,
                                                    input logic [CELL_BITS-1:0] col,
                                                    input cell_report_type want);
      directed_row_type d;
      d = req_row(cmd, code, row, col);
      d.fixed = 1'b1;
      d.report = want;
      return d;
   endfunction

   // Offers one request and holds it until the block takes it. The prediction is made at
   // the accepting edge; a random gap may follow when the sender is allowed to idle.
   task automatic offer_request(input logic [CMD_WIDTH-1:0] cmd,
                                input logic [CODE_WIDTH-1:0] code,
                                input logic [CELL_BITS-1:0] row,
                                input logic [CELL_BITS-1:0] col,
                                input bit fixed,
                                input cell_report_type fixed_report);
      cell_report_type predicted;
      req_bus.valid       <= 1'b1;
      req_bus.command     <= cmd;
      req_bus.symbol_code <= code;
      req_bus.read_row    <= row;
      req_bus.read_col    <= col;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = histogram_step(cmd, code, row, col);
      if (predicted.point_valid) begin
         last_row = predicted.row;
         last_col = predicted.col;
      end
      pending_reports.push_back(fixed ? fixed_report : predicted);
      if (req_idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Lets every outstanding response drain, then waits out any clearing pass so that
   // the block is truly idle before the caller touches a register.
   task automatic wait_until_idle();
      req_bus.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   // The wait after each write keeps back-to-back writes from driving the enable twice
   // within one time step.
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_ALPHABET: cfg_protein = value[0];
         CSR_ROUND:    cfg_round = value[0];
         CSR_GRID:     cfg_grid = value;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic compare_field(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Response side: checks every accepted response against the oldest expectation and
   // throttles ready, either in short random bursts or in one long hold-off on request.
   initial begin : response_side
      cell_report_type want;
      int              stall_left;
      int              hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               $display("%0t: response with none expected, expected nothing, %s%0d %0d %0d",
                        $time, "actual row col count ", rsp_bus.cell_row,
                        rsp_bus.cell_col, rsp_bus.cell_count);
            end else begin
               want = pending_reports.pop_front();
               compare_field("point_valid", 32'(want.point_valid), 32'(rsp_bus.point_valid));
               compare_field("cell_row", 32'(want.row), 32'(rsp_bus.cell_row));
               compare_field("cell_col", 32'(want.col), 32'(rsp_bus.cell_col));
               compare_field("cell_count", want.count, rsp_bus.cell_count);
               compare_field("nonzero_cells", 32'(want.nonzero), 32'(rsp_bus.nonzero_cells));
            end
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
         end
      end
   end

   // Watchdog: a long run of cycles with no handshake on either channel means a hang.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("chaos_game_histogram_unit test failed");
      $finish;
   end

   initial begin : stimulus
      logic [CMD_WIDTH-1:0]      cmd;
      logic [CODE_WIDTH-1:0]     code;
      logic [CELL_BITS-1:0]      row;
      logic [CELL_BITS-1:0]      col;
      logic [CSR_DATA_WIDTH-1:0] grid;
      int unsigned               pick;
      cell_report_type           none;

      none = '0;
      reset               <= 1'b1;
      csr_write           <= 1'b0;
      csr_index           <= CSR_ALPHABET;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.command     <= CMD_SYMBOL;
      req_bus.symbol_code <= '0;
      req_bus.read_row    <= '0;
      req_bus.read_col    <= '0;

      cfg_protein = 1'b0;
      cfg_round = 1'b0;
      cfg_grid = GRID_RESET;
      clear_store();
      recentre_point();

      // Directed plan. Starting from the centre of the full grid, a first symbol toward
      // the origin corner always lands on cell (32, 32), which makes several of these
      // results easy to write down by hand.
      directed_plan.push_back(checked_row(CMD_READ, 5'd0, 7'd0, 7'd0, none));
      directed_plan.push_back(checked_row(CMD_READ, 5'd0, 7'd127, 7'd127,
                                          '{1'b0, 7'd127, 7'd127, 32'd0, 15'd0}));
      directed_plan.push_back(checked_row(CMD_SYMBOL, 5'd0, 7'd0, 7'd0,
                                          '{1'b1, 7'd32, 7'd32, 32'd1, 15'd1}));
      // Codes just past the nucleotide range and the largest code are both gaps.
      directed_plan.push_back(checked_row(CMD_SYMBOL, 5'd4, 7'd0, 7'd0,
                                          '{1'b0, 7'd0, 7'd0, 32'd0, 15'd1}));
      directed_plan.push_back(checked_row(CMD_SYMBOL, 5'd31, 7'd127, 7'd127,
                                          '{1'b0, 7'd0, 7'd0, 32'd0, 15'd1}));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd1, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd2, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd3, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_READ, 5'd0, 7'd32, 7'd32));
      directed_plan.push_back(req_row(CMD_UNUSED, 5'd31, 7'd127, 7'd0));
      directed_plan.push_back(checked_row(CMD_START, 5'd0, 7'd0, 7'd0, none));
      directed_plan.push_back(checked_row(CMD_READ, 5'd0, 7'd32, 7'd32,
                                          '{1'b0, 7'd32, 7'd32, 32'd0, 15'd0}));
      // Protein alphabet: the last residue, the first code past it, and one of each group.
      directed_plan.push_back(csr_row(CSR_ALPHABET, 8'd1));
      directed_plan.push_back(checked_row(CMD_SYMBOL, 5'd19, 7'd0, 7'd0,
                                          '{1'b1, 7'd32, 7'd32, 32'd1, 15'd1}));
      directed_plan.push_back(checked_row(CMD_SYMBOL, 5'd20, 7'd0, 7'd0,
                                          '{1'b0, 7'd0, 7'd0, 32'd0, 15'd1}));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd3, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd1, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd18, 7'd0, 7'd0));
      directed_plan.push_back(csr_row(CSR_ROUND, 8'd1));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd5, 7'd0, 7'd0));
      // Shrinking the grid leaves the point outside it, so the cell index is pinned.
      directed_plan.push_back(csr_row(CSR_GRID, 8'd2));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd0, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd2, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd8, 7'd0, 7'd0));
      // Grid values below the minimum and above the maximum are clamped.
      directed_plan.push_back(csr_row(CSR_GRID, 8'd0));
      directed_plan.push_back(checked_row(CMD_START, 5'd0, 7'd0, 7'd0, none));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd2, 7'd0, 7'd0));
      directed_plan.push_back(req_row(CMD_READ, 5'd0, 7'd1, 7'd1));
      directed_plan.push_back(csr_row(CSR_GRID, 8'd255));
      directed_plan.push_back(checked_row(CMD_START, 5'd0, 7'd0, 7'd0, none));
      directed_plan.push_back(req_row(CMD_SYMBOL, 5'd7, 7'd0, 7'd0));
      directed_plan.push_back(csr_row(CSR_GRID, 8'(GRID_SIZE)));
      directed_plan.push_back(csr_row(CSR_ROUND, 8'd0));
      directed_plan.push_back(csr_row(CSR_ALPHABET, 8'd0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            wait_until_idle();
            write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
         end else begin
            offer_request(directed_plan[i].command, directed_plan[i].code,
                          directed_plan[i].row, directed_plan[i].col,
                          directed_plan[i].fixed, directed_plan[i].report);
         end
      end

      // Random phases. Each one starts from a quiet block with fresh register values;
      // symbols dominate so that the point wanders over the whole grid, and reads often
      // revisit the most recently hit cell so that non-zero counts are seen.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_idle();
         write_register(CSR_ALPHABET, 8'($urandom_range(0, 1)));
         write_register(CSR_ROUND, 8'($urandom_range(0, 1)));
         case ($urandom_range(0, 9))
            0:       grid = 8'd0;
            1:       grid = 8'd1;
            2:       grid = 8'd255;
            3:       grid = 8'(GRID_SIZE);
            default: grid = 8'($urandom_range(2, GRID_SIZE));
         endcase
         write_register(CSR_GRID, grid);

         // One phase runs without any idling, and so does the final one.
         req_idle_on = (phase != 2) && (phase != PHASES - 1);
         rsp_idle_on = req_idle_on;
         if (phase == PRESSURE_PHASE) begin
            // The receiver holds off while requests keep coming, so the queue fills
            // and the block has to push back on its input.
            req_idle_on = 1'b0;
            hold_request = 1'b1;
         end

         if ($urandom_range(0, 1) == 0) begin
            offer_request(CMD_START, CODE_WIDTH'($urandom_range(0, 31)),
                          CELL_BITS'($urandom_range(0, 127)),
                          CELL_BITS'($urandom_range(0, 127)), 1'b0, none);
         end

         repeat (ITEMS_PER_PHASE) begin
            code = CODE_WIDTH'($urandom_range(0, 31));
            row = CELL_BITS'($urandom_range(0, 127));
            col = CELL_BITS'($urandom_range(0, 127));
            pick = $urandom_range(0, 199);
            if (pick < 140) begin
               cmd = CMD_SYMBOL;
               if ($urandom_range(0, 5) != 0) begin
                  code = cfg_protein ? CODE_WIDTH'($urandom_range(0, 19))
                                     : CODE_WIDTH'($urandom_range(0, 3));
               end
            end else if (pick < 184) begin
               cmd = CMD_READ;
               if ($urandom_range(0, 1) == 0) begin
                  row = last_row;
                  col = last_col;
               end
            end else if (pick < 198) begin
               cmd = CMD_UNUSED;
            end else begin
               cmd = CMD_START;
            end
            offer_request(cmd, code, row, col, 1'b0, none);
         end
      end

      wait_until_idle();
      if (mismatches == 0) begin
         $display("chaos_game_histogram_unit test passed");
      end else begin
         $display("chaos_game_histogram_unit test failed");
      end
      $finish;
   end

endmodule
